>>> hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// MIDI input event queue package
// Shared constants, entry layout and the command and result types.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PHASE_W     = 3;
  localparam int TICK_DIVIDE = 6;
  localparam int ENTRY_W     = 27;

  localparam logic [7:0] TICK_STATUS  = 8'hF8;
  localparam logic [7:0] START_STATUS = 8'hFA;
  localparam logic [7:0] STOP_STATUS  = 8'hFC;
  localparam logic [3:0] CHAN_MASK    = 4'hF;

  localparam logic [3:0] KIND_NOTE_OFF    = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
  localparam logic [3:0] KIND_PITCH_WHEEL = 4'hE;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         chan;
    logic [7:0]         d1;
    logic [7:0]         d2;
    logic [PHASE_W-1:0] phase;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NOP  = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_READ = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    entry_t  entry;
  } cmd_t;

  // Handshake between a command producer and consumer.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic               read_valid;
    logic [3:0]         msg_kind;
    logic [3:0]         msg_channel;
    logic [7:0]         out_first_data;
    logic [7:0]         out_second_data;
    logic [PHASE_W-1:0] tick_phase;
    logic               event_queued;
    logic               event_dropped;
  } result_t;

endpackage

>>> hw/rtl/mie_if.sv
// ----------------------------------------------------------------------------
// MIDI input event queue channels
// Valid/ready request channel and result channel.
// ----------------------------------------------------------------------------
interface mie_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;

  modport source (output valid, req_type, status_byte, first_data, second_data,
                  input ready);
  modport sink (input valid, req_type, status_byte, first_data, second_data,
                output ready);
endinterface

interface mie_out_if;
  logic       valid;
  logic       ready;
  logic       read_valid;
  logic [3:0] msg_kind;
  logic [3:0] msg_channel;
  logic [7:0] out_first_data;
  logic [7:0] out_second_data;
  logic [2:0] tick_phase;
  logic       event_queued;
  logic       event_dropped;

  modport source (output valid, read_valid, msg_kind, msg_channel, out_first_data,
                  out_second_data, tick_phase, event_queued, event_dropped,
                  input ready);
  modport sink (input valid, read_valid, msg_kind, msg_channel, out_first_data,
                out_second_data, tick_phase, event_queued, event_dropped,
                output ready);
endinterface

>>> hw/rtl/midi_input_event_fifo.sv
// ----------------------------------------------------------------------------
// MIDI input event queue
// Filters MIDI events into a ring queue of messages and pops them on request.
// ----------------------------------------------------------------------------
// A request passes the two-entry command buffer; the back end goes from idle to
// hold for an event or empty read, and via read to hold for a read that pops an
// entry from the registered-read queue RAM. The back end takes a new request only
// when idle, once the receiver has taken the held result.
// Reset: synchronous active-low rst_n empties the queue and clears the tick
// divider and master_sync; the queue RAM contents are not cleared.
module midi_input_event_fifo (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  mie_in_if.sink    in_chan,
  mie_out_if.source out_chan
);
  import mie_pkg::*;

  cmd_req_t push_req;
  logic     push_ready;
  cmd_req_t pop_req;
  logic     pop_ready;

  mie_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .push_req    (push_req),
    .push_ready  (push_ready)
  );

  mie_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop_req    (pop_req),
    .pop_ready  (pop_ready)
  );

  mie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_req   (pop_req),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

>>> hw/rtl/mie_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mie_front.sv
// ----------------------------------------------------------------------------
// MIDI input event queue front end
// Accepts requests, filters MIDI events and runs the tick divider.
// ----------------------------------------------------------------------------
module mie_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  mie_in_if.sink           in_chan,
  output mie_pkg::cmd_req_t push_req,
  input  logic             push_ready
);
  import mie_pkg::*;

  logic               master_sync_r;
  logic [PHASE_W-1:0] tick_cnt_r;
  logic [PHASE_W-1:0] tick_cnt_nxt;
  logic               accept;
  logic [3:0]         kind;
  logic [3:0]         chan;
  cmd_t               cmd;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && push_ready;
  assign kind          = in_chan.status_byte[7:4];
  assign chan          = in_chan.status_byte[3:0] & CHAN_MASK;

  always_comb begin
    tick_cnt_nxt    = tick_cnt_r;
    cmd.op          = CMD_NOP;
    cmd.entry.kind  = kind;
    cmd.entry.chan  = chan;
    cmd.entry.d1    = in_chan.first_data;
    cmd.entry.d2    = in_chan.second_data;
    cmd.entry.phase = tick_cnt_r;
    if (in_chan.req_type) begin
      cmd.op = CMD_READ;
    end else if (in_chan.status_byte == TICK_STATUS) begin
      if (master_sync_r) begin
        // Every sixth tick wraps the divider and is queued at phase zero.
        if (tick_cnt_r == PHASE_W'(TICK_DIVIDE - 1)) begin
          tick_cnt_nxt    = '0;
          cmd.op          = CMD_PUSH;
          cmd.entry.phase = '0;
        end else begin
          tick_cnt_nxt = tick_cnt_r + PHASE_W'(1);
        end
      end
    end else if (in_chan.status_byte == START_STATUS ||
                 in_chan.status_byte == STOP_STATUS) begin
      tick_cnt_nxt = '0;
    end else if (kind inside {KIND_NOTE_OFF, KIND_NOTE_ON, KIND_PITCH_WHEEL}) begin
      cmd.op = CMD_PUSH;
    end
  end

  assign push_req.valid = in_chan.valid;
  assign push_req.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_sync_r <= 1'b0;
      tick_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        master_sync_r <= cfg_wr_data;
      end
      if (accept) begin
        tick_cnt_r <= tick_cnt_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/mie_cmd_fifo.sv
// ----------------------------------------------------------------------------
// MIDI input event queue command buffer
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mie_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  mie_pkg::cmd_req_t push_req,
  output logic              push_ready,
  output mie_pkg::cmd_req_t pop_req,
  input  logic              pop_ready
);
  import mie_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready    = (cnt_r != 2'd2);
  assign do_push       = push_req.valid && push_ready;
  assign pop_req.valid = (cnt_r != 2'd0);
  assign pop_req.cmd   = slot_r[rd_ptr_r];
  assign do_pop        = pop_req.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/mie_back.sv
// ----------------------------------------------------------------------------
// MIDI input event queue back end
// Owns the message ring queue, executes commands and holds the result.
// ----------------------------------------------------------------------------
module mie_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mie_pkg::cmd_req_t pop_req,
  output logic              pop_ready,
  mie_out_if.source         out_chan
);
  import mie_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  result_t          res_r, res_nxt;

  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  assign rd_entry  = entry_t'(ram_rdata);
  assign pop_ready = (state_r == ST_IDLE);

  mie_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (pop_req.cmd.entry),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (pop_req.valid) begin
          res_nxt   = '0;
          state_nxt = ST_HOLD;
          case (pop_req.cmd.op)
            CMD_READ: begin
              if (cnt_r != '0) begin
                ram_re     = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_r + PTR_W'(1);
                cnt_nxt    = cnt_r - CNT_W'(1);
                state_nxt  = ST_READ;
              end
            end
            CMD_PUSH: begin
              if (cnt_r != CNT_W'(QUEUE_DEPTH)) begin
                ram_we               = 1'b1;
                wr_ptr_nxt           = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + PTR_W'(1);
                cnt_nxt              = cnt_r + CNT_W'(1);
                res_nxt.event_queued = 1'b1;
              end else begin
                // A full queue keeps its contents and the request is flagged.
                res_nxt.event_dropped = 1'b1;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        res_nxt.read_valid      = 1'b1;
        res_nxt.msg_kind        = rd_entry.kind;
        res_nxt.msg_channel     = rd_entry.chan;
        res_nxt.out_first_data  = rd_entry.d1;
        res_nxt.out_second_data = rd_entry.d2;
        res_nxt.tick_phase      = rd_entry.phase;
        state_nxt               = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_chan.valid           = (state_r == ST_HOLD);
  assign out_chan.read_valid      = res_r.read_valid;
  assign out_chan.msg_kind        = res_r.msg_kind;
  assign out_chan.msg_channel     = res_r.msg_channel;
  assign out_chan.out_first_data  = res_r.out_first_data;
  assign out_chan.out_second_data = res_r.out_second_data;
  assign out_chan.tick_phase      = res_r.tick_phase;
  assign out_chan.event_queued    = res_r.event_queued;
  assign out_chan.event_dropped   = res_r.event_dropped;

endmodule

>>> test/mie_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI input event queue checker
// Watches both channels and the sync register write port, keeps its own copy
// of the message queue and tick divider, and compares every result field by
// field with the prediction made when the request was accepted.
// ----------------------------------------------------------------------------
module mie_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  mie_in_if    in_mon,
  mie_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);
  import mie_pkg::*;

  entry_t             queued_msgs[$];
  result_t            predicted_results[$];
  logic               sync_on;
  logic [PHASE_W-1:0] tick_div;

  function automatic result_t predict_midi_result(logic req, logic [7:0] status,
                                                  logic [7:0] d1, logic [7:0] d2);
    result_t res;
    entry_t  msg;
    logic    qualifies;
    res = '0;
    msg = '0;
    qualifies = 1'b0;
    if (req) begin
      if (queued_msgs.size() != 0) begin
        msg = queued_msgs.pop_front();
        res.read_valid      = 1'b1;
        res.msg_kind        = msg.kind;
        res.msg_channel     = msg.chan;
        res.out_first_data  = msg.d1;
        res.out_second_data = msg.d2;
        res.tick_phase      = msg.phase;
      end
      return res;
    end
    if (status == TICK_STATUS) begin
      // Only every sixth tick becomes a message, and only with master sync on.
      if (sync_on) begin
        if (int'(tick_div) + 1 >= TICK_DIVIDE) begin
          tick_div  = '0;
          qualifies = 1'b1;
        end else begin
          tick_div = tick_div + PHASE_W'(1);
        end
      end
    end else if (status == START_STATUS || status == STOP_STATUS) begin
      tick_div = '0;
    end else if (status[7:4] == KIND_NOTE_OFF || status[7:4] == KIND_NOTE_ON ||
                 status[7:4] == KIND_PITCH_WHEEL) begin
      qualifies = 1'b1;
    end
    if (qualifies) begin
      if (queued_msgs.size() >= QUEUE_DEPTH) begin
        res.event_dropped = 1'b1;
      end else begin
        msg.kind  = status[7:4];
        msg.chan  = status[3:0] & CHAN_MASK;
        msg.d1    = d1;
        msg.d2    = d2;
        msg.phase = tick_div;
        queued_msgs.insert(queued_msgs.size(), msg);
        res.event_queued = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      fail_count++;
      $display("%0t: result with no request outstanding, expected none, got %0h",
               $time, {out_mon.read_valid, out_mon.msg_kind, out_mon.msg_channel,
                       out_mon.out_first_data, out_mon.out_second_data,
                       out_mon.tick_phase, out_mon.event_queued, out_mon.event_dropped});
      return;
    end
    want = predicted_results.pop_front();
    compare_field("read_valid", 8'(want.read_valid), 8'(out_mon.read_valid));
    compare_field("msg_kind", 8'(want.msg_kind), 8'(out_mon.msg_kind));
    compare_field("msg_channel", 8'(want.msg_channel), 8'(out_mon.msg_channel));
    compare_field("out_first_data", want.out_first_data, out_mon.out_first_data);
    compare_field("out_second_data", want.out_second_data, out_mon.out_second_data);
    compare_field("tick_phase", 8'(want.tick_phase), 8'(out_mon.tick_phase));
    compare_field("event_queued", 8'(want.event_queued), 8'(out_mon.event_queued));
    compare_field("event_dropped", 8'(want.event_dropped), 8'(out_mon.event_dropped));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      queued_msgs.delete();
      predicted_results.delete();
      sync_on    = 1'b0;
      tick_div   = '0;
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        sync_on = cfg_wr_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_results.insert(predicted_results.size(),
          predict_midi_result(in_mon.req_type, in_mon.status_byte,
                              in_mon.first_data, in_mon.second_data));
      end
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
    end
    pending_count = predicted_results.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI input event queue testbench
// Drives directed and random MIDI events and read requests through the queue
// under several sync settings and idle patterns; the checker judges results.
// ----------------------------------------------------------------------------
module tb_top;
  import mie_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // A status byte that the filter ignores.
  localparam logic [7:0] CONTROL_CHANGE = 8'hB3;

  // Share of read requests in a random phase, in percent.
  localparam int READS_FILL     = 3;
  localparam int READS_BALANCED = 40;
  localparam int READS_DRAIN    = 60;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_seq       = 0;
  int   fail_count;
  int   pending_count;
  int   stall_count;

  mie_in_if  in_chan ();
  mie_out_if out_chan ();

  midi_input_event_fifo dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  mie_checker msg_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off each time one is asked for.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_seq;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    stall_count = 0;
    while (stall_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(logic req, logic [7:0] status, logic [7:0] d1,
                              logic [7:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= req;
    in_chan.status_byte <= status;
    in_chan.first_data  <= d1;
    in_chan.second_data <= d2;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(logic value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(int read_pct);
    logic [7:0] status;
    logic [3:0] kind;
    int         pick;
    status = 8'($urandom_range(255));
    pick   = int'($urandom_range(99));
    kind   = KIND_NOTE_ON;
    if ($urandom_range(99) < read_pct) begin
      send_request(REQ_READ, status, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      if (pick < 55) begin
        case ($urandom_range(2))
          0: kind = KIND_NOTE_OFF;
          1: kind = KIND_NOTE_ON;
          default: kind = KIND_PITCH_WHEEL;
        endcase
        status = {kind, status[3:0]};
      end else if (pick < 80) begin
        status = TICK_STATUS;
      end else if (pick < 86) begin
        status = $urandom_range(1) ? START_STATUS : STOP_STATUS;
      end
      send_request(REQ_EVENT, status, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(logic sync, int idle_pct, int stall_pct, int read_pct,
                           int n_items, bit with_hold);
    write_sync(sync);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) begin
      hold_seq++;
    end
    repeat (n_items) send_random(read_pct);
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.req_type    <= REQ_EVENT;
    in_chan.status_byte <= 8'h00;
    in_chan.first_data  <= 8'h00;
    in_chan.second_data <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Master sync is off after reset, so the tick is ignored.
    send_request(REQ_READ, 8'h00, 8'h00, 8'h00);
    send_request(REQ_EVENT, TICK_STATUS, 8'h12, 8'h34);
    send_request(REQ_EVENT, {KIND_NOTE_ON, 4'h0}, 8'h00, 8'h00);
    send_request(REQ_EVENT, {KIND_NOTE_OFF, 4'hF}, 8'hFF, 8'hFF);
    send_request(REQ_EVENT, {KIND_PITCH_WHEEL, 4'h5}, 8'h7F, 8'h80);
    send_request(REQ_EVENT, CONTROL_CHANGE, 8'h40, 8'h7F);
    send_request(REQ_EVENT, START_STATUS, 8'h00, 8'h00);
    repeat (4) send_request(REQ_READ, 8'hFF, 8'hFF, 8'hFF);

    // Seven ticks with a note after the fifth: the note carries phase 5 and the
    // sixth tick is queued with phase 0.
    write_sync(1'b1);
    repeat (5) send_request(REQ_EVENT, TICK_STATUS, 8'hA5, 8'h5A);
    send_request(REQ_EVENT, {KIND_NOTE_ON, 4'hA}, 8'h3C, 8'h64);
    send_request(REQ_EVENT, TICK_STATUS, 8'h01, 8'h02);
    send_request(REQ_EVENT, TICK_STATUS, 8'h03, 8'h04);
    send_request(REQ_EVENT, STOP_STATUS, 8'h00, 8'h00);
    send_request(REQ_EVENT, {KIND_NOTE_ON, 4'h1}, 8'h30, 8'h40);
    repeat (4) send_request(REQ_READ, 8'h00, 8'h00, 8'h00);

    run_phase(1'b1, 0, 0, READS_BALANCED, 200, 1'b0);
    run_phase(1'b1, 86, 0, READS_FILL, 150, 1'b0);
    run_phase(1'b0, 0, 86, READS_DRAIN, 200, 1'b0);
    run_phase(1'b1, 7, 7, READS_BALANCED, 200, 1'b1);
    run_phase(1'b0, 0, 0, READS_FILL, 125, 1'b0);
    run_phase(1'b1, 0, 86, READS_DRAIN, 150, 1'b0);

    wait_idle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
